### rtl/vgts_pkg.sv
package vgts_pkg;

    localparam int DIM_X_DEF = 32;
    localparam int DIM_Y_DEF = 32;
    localparam int DIM_Z_DEF = 32;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_SAMPLE = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    localparam logic [2:0] CFG_ORIGIN_X   = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y   = 3'd1;
    localparam logic [2:0] CFG_ORIGIN_Z   = 3'd2;
    localparam logic [2:0] CFG_VOXEL_SIZE = 3'd3;
    localparam logic [2:0] CFG_INV_SIZE   = 3'd4;

    localparam logic [2:0] LAST_AXIS  = 3'd2;
    localparam logic [2:0] LAST_FETCH = 3'd7;
    localparam logic [2:0] LAST_LERP  = 3'd6;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD,
        ST_RDOUT,
        ST_MUL,
        ST_ACC,
        ST_FETCH,
        ST_WAIT,
        ST_LERP
    } vgts_state_t;

    typedef struct packed {
        logic       clear;
        logic       accept;
        logic       write;
        logic       rd;
        logic       mul;
        logic       acc;
        logic       fetch;
        logic       lerp;
        logic       load_rd;
        logic       load_smp;
        logic [2:0] idx;
    } vgts_cmd_t;

    typedef struct packed {
        logic clear_last;
    } vgts_status_t;

    typedef struct packed {
        logic [2:0] a;
        logic [2:0] b;
        logic [1:0] axis;
    } vgts_lerp_sel_t;

    // lerp order: x four, y two, z one; all results but the last land in operand a
    function automatic vgts_lerp_sel_t lerp_sel(logic [2:0] step);
        vgts_lerp_sel_t s;
        unique case (step)
            3'd0:    s = '{a: 3'd0, b: 3'd1, axis: 2'd0};
            3'd1:    s = '{a: 3'd2, b: 3'd3, axis: 2'd0};
            3'd2:    s = '{a: 3'd4, b: 3'd5, axis: 2'd0};
            3'd3:    s = '{a: 3'd6, b: 3'd7, axis: 2'd0};
            3'd4:    s = '{a: 3'd0, b: 3'd2, axis: 2'd1};
            3'd5:    s = '{a: 3'd4, b: 3'd6, axis: 2'd1};
            default: s = '{a: 3'd0, b: 3'd4, axis: 2'd2};
        endcase
        return s;
    endfunction

endpackage

### rtl/voxel_grid_trilinear_sampler_core.sv
// Trilinear voxel-grid sampler. After reset the block clears its DIM_X*DIM_Y*DIM_Z
// entry store (32768 entries at default size, one entry a cycle) with busy high;
// configuration writes are taken during that sweep. A command beat is taken when
// start is high and busy is low. A write finishes in the accepting cycle and keeps
// busy low. A read holds busy through ST_RD and ST_RDOUT. A sample holds busy
// through ST_MUL and ST_ACC for the three grid coordinates (one axis at a time,
// each product split into two partial products), ST_FETCH for the 8 corner reads
// from the single-port store, ST_WAIT for the last read data, and ST_LERP for 7
// serial lerps. done is a one-cycle strobe with distance valid in that cycle,
// and busy is already low then; there is no stall, so capture it then.
module voxel_grid_trilinear_sampler_core
    import vgts_pkg::*;
#(
    parameter int DIM_X = DIM_X_DEF,
    parameter int DIM_Y = DIM_Y_DEF,
    parameter int DIM_Z = DIM_Z_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         op,
    input  logic signed [8:0]  voxel_x,
    input  logic signed [8:0]  voxel_y,
    input  logic signed [8:0]  voxel_z,
    input  logic signed [15:0] write_value,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output logic               done,
    output logic signed [15:0] distance
);

    vgts_cmd_t    cmd;
    vgts_status_t status;

    vgts_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .op     (op),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    vgts_datapath #(
        .DIM_X (DIM_X),
        .DIM_Y (DIM_Y),
        .DIM_Z (DIM_Z)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .voxel_x     (voxel_x),
        .voxel_y     (voxel_y),
        .voxel_z     (voxel_z),
        .write_value (write_value),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_z     (point_z),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .distance    (distance)
    );

    a_done_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without a command in flight");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && op == OP_WRITE) |=> (!done && !busy))
        else $error("write beat produced a result or stalled");

    a_free_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("controller still busy at result beat");

endmodule

### rtl/vgts_ctrl.sv
module vgts_ctrl
    import vgts_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [1:0]   op,
    input  vgts_status_t status,
    output vgts_cmd_t    cmd,
    output logic         busy,
    output logic         done
);

    vgts_state_t state_reg, state_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= 3'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= cmd.load_rd | cmd.load_smp;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (status.clear_last)
                    state_next = ST_IDLE;
            ST_IDLE:
            begin
                cnt_next = 3'd0;
                if (start && op == OP_READ)
                    state_next = ST_RD;
                else if (start && op == OP_SAMPLE)
                    state_next = ST_MUL;
            end
            ST_RD:
                state_next = ST_RDOUT;
            ST_RDOUT:
                state_next = ST_IDLE;
            ST_MUL:
                state_next = ST_ACC;
            ST_ACC:
            begin
                if (cnt_reg == LAST_AXIS)
                begin
                    state_next = ST_FETCH;
                    cnt_next   = 3'd0;
                end
                else
                begin
                    state_next = ST_MUL;
                    cnt_next   = cnt_reg + 3'd1;
                end
            end
            ST_FETCH:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == LAST_FETCH)
                    state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                state_next = ST_LERP;
                cnt_next   = 3'd0;
            end
            ST_LERP:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == LAST_LERP)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd     = '0;
        cmd.idx = cnt_reg;
        unique case (state_reg)
            ST_CLEAR:
                cmd.clear = 1'b1;
            ST_IDLE:
            begin
                cmd.accept = start;
                cmd.write  = start && op == OP_WRITE;
            end
            ST_RD:    cmd.rd = 1'b1;
            ST_RDOUT: cmd.load_rd = 1'b1;
            ST_MUL:   cmd.mul = 1'b1;
            ST_ACC:   cmd.acc = 1'b1;
            ST_FETCH: cmd.fetch = 1'b1;
            ST_WAIT:  ;
            ST_LERP:
            begin
                cmd.lerp     = cnt_reg != LAST_LERP;
                cmd.load_smp = cnt_reg == LAST_LERP;
            end
            default:  cmd = '0;
        endcase
    end

    assign busy = state_reg != ST_IDLE;
    assign done = done_reg;

endmodule

### rtl/vgts_datapath.sv
module vgts_datapath
    import vgts_pkg::*;
#(
    parameter int DIM_X = DIM_X_DEF,
    parameter int DIM_Y = DIM_Y_DEF,
    parameter int DIM_Z = DIM_Z_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  vgts_cmd_t          cmd,
    output vgts_status_t       status,
    input  logic signed [8:0]  voxel_x,
    input  logic signed [8:0]  voxel_y,
    input  logic signed [8:0]  voxel_z,
    input  logic signed [15:0] write_value,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output logic signed [15:0] distance
);

    localparam int DEPTH = DIM_X * DIM_Y * DIM_Z;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(DIM_X);
    localparam int YW    = $clog2(DIM_Y);
    localparam int ZW    = $clog2(DIM_Z);

    function automatic logic in_rng(logic signed [33:0] c, logic [8:0] dim);
        return (c >= 34'sd0) && (c < $signed(34'(dim)));
    endfunction

    function automatic logic [AW-1:0] addr_of(logic signed [33:0] cx,
                                              logic signed [33:0] cy,
                                              logic signed [33:0] cz);
        return AW'(cx[XW-1:0]) + AW'(DIM_X) * AW'(cy[YW-1:0])
             + AW'(DIM_X * DIM_Y) * AW'(cz[ZW-1:0]);
    endfunction

    function automatic logic in_grid(logic signed [33:0] cx,
                                     logic signed [33:0] cy,
                                     logic signed [33:0] cz);
        return in_rng(cx, 9'(DIM_X)) && in_rng(cy, 9'(DIM_Y)) && in_rng(cz, 9'(DIM_Z));
    endfunction

    logic signed [31:0] org_reg [3];
    logic [30:0]        vsize_reg;
    logic [30:0]        inv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_reg[0] <= '0;
            org_reg[1] <= '0;
            org_reg[2] <= '0;
            vsize_reg  <= 31'd65536;
            inv_reg    <= 31'd65536;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_ORIGIN_X:   org_reg[0] <= cfg_data;
                CFG_ORIGIN_Y:   org_reg[1] <= cfg_data;
                CFG_ORIGIN_Z:   org_reg[2] <= cfg_data;
                CFG_VOXEL_SIZE: vsize_reg  <= cfg_data[30:0];
                CFG_INV_SIZE:   inv_reg    <= cfg_data[30:0];
                default:        vsize_reg  <= vsize_reg;
            endcase
        end
    end

    logic signed [15:0] fallback;
    assign fallback = (vsize_reg[30:4] > 27'd32767) ? 16'sd32767
                                                    : $signed({1'b0, vsize_reg[18:4]});

    // clear sweep
    logic [AW-1:0] clr_cnt_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (cmd.clear)
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
    end
    assign status.clear_last = clr_cnt_reg == AW'(DEPTH - 1);

    // latched beat
    logic signed [8:0]  vx_reg, vy_reg, vz_reg;
    logic signed [32:0] d_reg [3];
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            vx_reg   <= voxel_x;
            vy_reg   <= voxel_y;
            vz_reg   <= voxel_z;
            d_reg[0] <= 33'(point_x) - 33'(org_reg[0]);
            d_reg[1] <= 33'(point_y) - 33'(org_reg[1]);
            d_reg[2] <= 33'(point_z) - 33'(org_reg[2]);
        end
    end

    // grid coordinate: 33x31 product in two partial products
    logic signed [49:0] p_lo_reg;
    logic signed [48:0] p_hi_reg;
    logic signed [33:0] c0_reg [3];
    logic [15:0]        t_reg  [3];
    logic signed [65:0] prod;
    logic signed [49:0] fq;

    assign prod = 66'(p_lo_reg) + (66'(p_hi_reg) <<< 16);
    assign fq   = 50'(prod >>> 16) - 50'sd32768;

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            p_lo_reg <= d_reg[cmd.idx[1:0]] * $signed({1'b0, inv_reg[15:0]});
            p_hi_reg <= d_reg[cmd.idx[1:0]] * $signed({1'b0, inv_reg[30:16]});
        end
        if (cmd.acc)
        begin
            c0_reg[cmd.idx[1:0]] <= 34'(fq >>> 16);
            t_reg[cmd.idx[1:0]]  <= fq[15:0];
        end
    end

    // voxel store
    logic [15:0]        mem [DEPTH];
    logic signed [33:0] wx, wy, wz, rx, ry, rz;
    logic [AW-1:0]      rd_addr;
    logic               rd_in;
    logic [15:0]        q_reg;
    logic               oob_reg;

    assign wx = 34'(voxel_x);
    assign wy = 34'(voxel_y);
    assign wz = 34'(voxel_z);

    always_comb
    begin
        if (cmd.fetch)
        begin
            rx = c0_reg[0] + 34'(cmd.idx[0]);
            ry = c0_reg[1] + 34'(cmd.idx[1]);
            rz = c0_reg[2] + 34'(cmd.idx[2]);
        end
        else
        begin
            rx = 34'(vx_reg);
            ry = 34'(vy_reg);
            rz = 34'(vz_reg);
        end
    end
    assign rd_addr = addr_of(rx, ry, rz);
    assign rd_in   = in_grid(rx, ry, rz);

    always_ff @(posedge clk)
    begin
        if (cmd.clear)
            mem[clr_cnt_reg] <= '0;
        else if (cmd.write && in_grid(wx, wy, wz))
            mem[addr_of(wx, wy, wz)] <= write_value;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd || cmd.fetch)
        begin
            q_reg   <= mem[rd_addr];
            oob_reg <= !rd_in;
        end
    end

    logic       cap_reg;
    logic [2:0] cap_idx_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg     <= 1'b0;
            cap_idx_reg <= 3'd0;
        end
        else
        begin
            cap_reg     <= cmd.fetch;
            cap_idx_reg <= cmd.idx;
        end
    end

    logic signed [15:0] fetched;
    assign fetched = oob_reg ? fallback : $signed(q_reg);

    // serial lerp unit
    logic signed [15:0] v_reg [8];
    vgts_lerp_sel_t     sel;
    logic signed [16:0] diff;
    logic signed [33:0] mprod;
    logic signed [17:0] lres;
    logic signed [15:0] lsat;

    assign sel   = lerp_sel(cmd.idx);
    assign diff  = 17'(v_reg[sel.b]) - 17'(v_reg[sel.a]);
    assign mprod = diff * $signed({1'b0, t_reg[sel.axis]});
    assign lres  = 18'(v_reg[sel.a]) + 18'(mprod >>> 16);
    assign lsat  = (lres > 18'sd32767) ? 16'sd32767
                 : (lres < -18'sd32768) ? -16'sd32768 : lres[15:0];

    always_ff @(posedge clk)
    begin
        if (cap_reg)
            v_reg[cap_idx_reg] <= fetched;
        else if (cmd.lerp)
            v_reg[sel.a] <= lsat;
    end

    logic signed [15:0] out_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.load_rd)
            out_reg <= fetched;
        else if (cmd.load_smp)
            out_reg <= lsat;
    end
    assign distance = out_reg;

endmodule

### tb/sv/vgts_sample_checker.sv
module vgts_sample_checker
    import vgts_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [1:0]         op,
    input  logic signed [8:0]  voxel_x,
    input  logic signed [8:0]  voxel_y,
    input  logic signed [8:0]  voxel_z,
    input  logic signed [15:0] write_value,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               done,
    input  logic signed [15:0] distance,
    output int                 errors,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NX = DIM_X_DEF;
    localparam int NY = DIM_Y_DEF;
    localparam int NZ = DIM_Z_DEF;

    logic [15:0] grid_mem [NX*NY*NZ];
    longint      org_x, org_y, org_z;
    longint      vox_size, inv_size;
    logic [15:0] expected_distance [$];

    assign pending = expected_distance.size();

    function automatic bit in_grid(longint x, longint y, longint z);
        return x >= 0 && y >= 0 && z >= 0 && x < NX && y < NY && z < NZ;
    endfunction

    function automatic longint voxel_at(longint x, longint y, longint z);
        longint fb;
        if (!in_grid(x, y, z))
        begin
            fb = vox_size >>> 4;
            return fb > 32767 ? 32767 : fb;
        end
        return longint'($signed(grid_mem[x + NX*(y + NY*z)]));
    endfunction

    function automatic longint blend(longint a, longint b, longint t);
        return a + (((b - a) * t) >>> 16);
    endfunction

    function automatic longint grid_pos(longint p, longint org);
        return (((p - org) * inv_size) >>> 16) - 32768;
    endfunction

    function automatic logic [15:0] trilinear_distance(longint px, longint py, longint pz);
        longint fx, fy, fz, x0, y0, z0, tx, ty, tz;
        longint c00, c10, c01, c11, c0, c1, r;
        fx = grid_pos(px, org_x);
        fy = grid_pos(py, org_y);
        fz = grid_pos(pz, org_z);
        x0 = fx >>> 16;
        y0 = fy >>> 16;
        z0 = fz >>> 16;
        tx = fx & 64'hFFFF;
        ty = fy & 64'hFFFF;
        tz = fz & 64'hFFFF;
        c00 = blend(voxel_at(x0, y0, z0), voxel_at(x0 + 1, y0, z0), tx);
        c10 = blend(voxel_at(x0, y0 + 1, z0), voxel_at(x0 + 1, y0 + 1, z0), tx);
        c01 = blend(voxel_at(x0, y0, z0 + 1), voxel_at(x0 + 1, y0, z0 + 1), tx);
        c11 = blend(voxel_at(x0, y0 + 1, z0 + 1), voxel_at(x0 + 1, y0 + 1, z0 + 1), tx);
        c0 = blend(c00, c10, ty);
        c1 = blend(c01, c11, ty);
        r = blend(c0, c1, tz);
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r[15:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (grid_mem[i])
                grid_mem[i] = '0;
            org_x = 0;
            org_y = 0;
            org_z = 0;
            vox_size = 65536;
            inv_size = 65536;
            expected_distance.delete();
            errors = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_distance.size() == 0)
                begin
                    $error("unexpected result beat: distance %0d", distance);
                    errors++;
                end
                else
                begin
                    if (distance !== expected_distance[0])
                    begin
                        $error("distance mismatch: expected %0d actual %0d",
                               $signed(expected_distance[0]), distance);
                        errors++;
                    end
                    void'(expected_distance.pop_front());
                end
            end
            if (start && !busy)
            begin
                case (op)
                    OP_WRITE:
                        if (in_grid(voxel_x, voxel_y, voxel_z))
                            grid_mem[voxel_x + NX*(voxel_y + NY*voxel_z)] = write_value;
                    OP_READ:
                        expected_distance.push_back(
                            16'(voxel_at(voxel_x, voxel_y, voxel_z)));
                    OP_SAMPLE:
                        expected_distance.push_back(
                            trilinear_distance(point_x, point_y, point_z));
                    default: ;
                endcase
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_ORIGIN_X:   org_x = longint'($signed(cfg_data));
                    CFG_ORIGIN_Y:   org_y = longint'($signed(cfg_data));
                    CFG_ORIGIN_Z:   org_z = longint'($signed(cfg_data));
                    CFG_VOXEL_SIZE: vox_size = longint'(cfg_data[30:0]);
                    CFG_INV_SIZE:   inv_size = longint'(cfg_data[30:0]);
                    default: ;
                endcase
            end
        end
    end

endmodule

### tb/sv/voxel_grid_trilinear_sampler_core_test.sv
module voxel_grid_trilinear_sampler_core_test;
    import vgts_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 200000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         op = OP_WRITE;
    logic signed [8:0]  voxel_x = '0;
    logic signed [8:0]  voxel_y = '0;
    logic signed [8:0]  voxel_z = '0;
    logic signed [15:0] write_value = '0;
    logic signed [31:0] point_x = '0;
    logic signed [31:0] point_y = '0;
    logic signed [31:0] point_z = '0;
    logic               cfg_write = 1'b0;
    logic [2:0]         cfg_index = CFG_ORIGIN_X;
    logic [31:0]        cfg_data = '0;
    logic               done;
    logic signed [15:0] distance;
    int                 errors;
    int                 pending;
    int                 idle_pct = 0;
    int                 quiet_cycles = 0;
    longint             cur_org [3];
    longint             cur_size = 65536;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    voxel_grid_trilinear_sampler_core u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op),
        .voxel_x(voxel_x), .voxel_y(voxel_y), .voxel_z(voxel_z),
        .write_value(write_value), .point_x(point_x), .point_y(point_y),
        .point_z(point_z), .cfg_write(cfg_write), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .done(done), .distance(distance)
    );

    vgts_sample_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op),
        .voxel_x(voxel_x), .voxel_y(voxel_y), .voxel_z(voxel_z),
        .write_value(write_value), .point_x(point_x), .point_y(point_y),
        .point_z(point_z), .cfg_write(cfg_write), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .done(done), .distance(distance),
        .errors(errors), .pending(pending)
    );

    always @(posedge clk)
    begin
        if ((start && !busy) || done || cfg_write)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("voxel_grid_trilinear_sampler_core_test: errors");
            $finish;
        end
    end

    // busy only moves at the rising edge, so a low busy seen at the falling edge
    // means the beat is taken at the next rising edge
    task automatic send_beat(logic [1:0] o, int x, int y, int z, int v,
                             longint px, longint py, longint pz);
        if ($urandom_range(99) < idle_pct)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        op = o;
        voxel_x = 9'(x);
        voxel_y = 9'(y);
        voxel_z = 9'(z);
        write_value = 16'(v);
        point_x = 32'(px);
        point_y = 32'(py);
        point_z = 32'(pz);
        start = 1'b1;
        while (busy)
            @(negedge clk);
        @(negedge clk);
    endtask

    task automatic set_reg(logic [2:0] idx, logic [31:0] val);
        cfg_index = idx;
        cfg_data = val;
        cfg_write = 1'b1;
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    task automatic drain();
        start = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    task automatic load_config(longint ox, longint oy, longint oz, longint vs, longint inv);
        set_reg(CFG_ORIGIN_X, ox[31:0]);
        set_reg(CFG_ORIGIN_Y, oy[31:0]);
        set_reg(CFG_ORIGIN_Z, oz[31:0]);
        set_reg(CFG_VOXEL_SIZE, vs[31:0]);
        set_reg(CFG_INV_SIZE, inv[31:0]);
        cur_org[0] = longint'($signed(ox[31:0]));
        cur_org[1] = longint'($signed(oy[31:0]));
        cur_org[2] = longint'($signed(oz[31:0]));
        cur_size = vs;
    endtask

    // world coordinate from -2 to +34 voxels around the origin
    function automatic longint near_grid(int axis);
        longint d;
        d = (longint'($urandom_range(0, 3600)) - 200) * cur_size / 100;
        return cur_org[axis] + d;
    endfunction

    task automatic random_beat();
        int pick;
        pick = $urandom_range(99);
        if (pick < 35)
            send_beat(OP_WRITE, $urandom_range(31), $urandom_range(31), $urandom_range(31),
                      $urandom, 0, 0, 0);
        else if (pick < 40)
            send_beat(OP_WRITE, $urandom, $urandom, $urandom, $urandom, 0, 0, 0);
        else if (pick < 62)
            send_beat(OP_READ, $urandom_range(31), $urandom_range(31), $urandom_range(31),
                      $urandom, $urandom, $urandom, $urandom);
        else if (pick < 67)
            send_beat(OP_READ, $urandom, $urandom, $urandom, $urandom, 0, 0, 0);
        else if (pick < 92)
            send_beat(OP_SAMPLE, $urandom, $urandom, $urandom, $urandom,
                      near_grid(0), near_grid(1), near_grid(2));
        else if (pick < 97)
            send_beat(OP_SAMPLE, 0, 0, 0, 0, $urandom, $urandom, $urandom);
        else
            send_beat(OP_NOP, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom);
    endtask

    initial
    begin
        longint vs;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        load_config(0, 0, 0, 65536, 65536);
        @(negedge clk);
        while (busy)
            @(negedge clk);

        // directed: store extremes, range edges, unused op, sample edges
        send_beat(OP_WRITE, 0, 0, 0, 32767, 0, 0, 0);
        send_beat(OP_WRITE, 31, 31, 31, -32768, 0, 0, 0);
        send_beat(OP_WRITE, 1, 0, 0, -32768, 0, 0, 0);
        send_beat(OP_WRITE, -256, 0, 0, 1234, 0, 0, 0);
        send_beat(OP_WRITE, 255, 255, 255, 1234, 0, 0, 0);
        send_beat(OP_WRITE, 32, 0, 0, 555, 0, 0, 0);
        send_beat(OP_READ, 0, 0, 0, 0, 0, 0, 0);
        send_beat(OP_READ, 31, 31, 31, 0, 0, 0, 0);
        send_beat(OP_READ, 1, 0, 0, 0, 0, 0, 0);
        send_beat(OP_READ, -1, 0, 0, 0, 0, 0, 0);
        send_beat(OP_READ, 0, 32, 0, 0, 0, 0, 0);
        send_beat(OP_READ, 0, 0, -256, 0, 0, 0, 0);
        send_beat(OP_NOP, 5, 5, 5, 77, 0, 0, 0);
        send_beat(OP_SAMPLE, 0, 0, 0, 0, 32768, 32768, 32768);
        send_beat(OP_SAMPLE, 0, 0, 0, 0, 65536, 32768, 32768);
        send_beat(OP_SAMPLE, 0, 0, 0, 0, 0, 0, 0);
        send_beat(OP_SAMPLE, 0, 0, 0, 0, 'h7FFFFFFF, 'h7FFFFFFF, 'h7FFFFFFF);
        send_beat(OP_SAMPLE, 0, 0, 0, 0, -2147483648, -2147483648, -2147483648);
        send_beat(OP_SAMPLE, 0, 0, 0, 0, 31*65536 + 32768, 31*65536 + 32768, 31*65536 + 32768);
        send_beat(OP_SAMPLE, 0, 0, 0, 0, 40000, 90000, 123456);
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: load_config(0, 0, 0, 65536, 65536);
                1: load_config(-200000, 300000, 12345, 16384, 262144);
                2: load_config(-2147483648, 'h7FFFFFFF, -2147483648, 1, 'h7FFFFFFF);
                3: load_config('h7FFFFFFF, -2147483648, 0, 'h7FFFFFFF, 1);
                4: load_config(-5000000, -7000000, 9000000, 1 << 20, 4096);
                default:
                begin
                    vs = $urandom_range(4096, 1 << 22);
                    load_config($urandom, $urandom, $urandom, vs, (64'd1 << 32) / vs);
                end
            endcase
            idle_pct = (phase < 2) ? 8 : (phase < 4) ? 80 : 0;
            repeat (230) random_beat();
            drain();
        end

        if (errors == 0)
            $display("voxel_grid_trilinear_sampler_core_test: clean");
        else
            $display("voxel_grid_trilinear_sampler_core_test: errors");
        $finish;
    end

endmodule
